[sv/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

	// Widths fixed by the matrix and quaternion formats.
	localparam int FIELD_W = 18;
	localparam int DIFF_W  = 19;
	localparam int QB      = 19;

	localparam logic signed [FIELD_W-1:0] SAT_HI = 18'sh1FFFF;
	localparam logic signed [FIELD_W-1:0] SAT_LO = 18'sh20000;

	// Which quaternion component takes the square root directly.
	typedef enum logic [1:0] {
		LEAD_X = 2'd0,
		LEAD_Y = 2'd1,
		LEAD_Z = 2'd2,
		LEAD_W = 2'd3
	} lead_t;

	// The three numerators that get divided by twice the root.
	typedef struct packed {
		lead_t                    lead;
		logic signed [DIFF_W-1:0] da;
		logic signed [DIFF_W-1:0] db;
		logic signed [DIFF_W-1:0] dc;
	} side_t;

	// Division results handed to the output stage.
	typedef struct packed {
		lead_t           lead;
		logic [2:0]      neg;
		logic [2:0]      ovf;
		logic [QB-1:0]   qa;
		logic [QB-1:0]   qb;
		logic [QB-1:0]   qc;
	} dv_t;

endpackage

[sv/rotation_matrix_to_quaternion_unit.sv]
// Top level of the rotation matrix to quaternion pipeline.
//
//  Channel  | Handshake       | Payload
//  ---------+-----------------+-----------------------------------------
//  matrix   | valid / stall   | m00 m01 m02 m10 m11 m12 m20 m21 m22
//  result   | q_valid/q_stall | qx qy qz qw degenerate
//
// One matrix is accepted per cycle while stall is low; the path runs through
// the front stage, the bit-per-stage square root, the bit-per-stage divider
// and the output register.
// Reset clears only the stage valid bits; the pipeline is empty afterwards.
// A stalled result holds its stage while empty stages upstream keep filling.
module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid,
	output logic                               stall,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m00,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m01,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m02,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m10,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m11,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m12,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m20,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m21,
	input  logic signed [rmq_pkg::FIELD_W-1:0] m22,
	output logic                               q_valid,
	input  logic                               q_stall,
	output logic signed [rmq_pkg::FIELD_W-1:0] qx,
	output logic signed [rmq_pkg::FIELD_W-1:0] qy,
	output logic signed [rmq_pkg::FIELD_W-1:0] qz,
	output logic signed [rmq_pkg::FIELD_W-1:0] qw,
	output logic                               degenerate
);
	import rmq_pkg::*;

	localparam int RW = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
	localparam int NB = (RW + FRAC_BITS + 1) / 2;

	logic          f_rdy, f_vld, r_rdy, r_vld, d_rdy, d_vld, b_rdy;
	logic [RW-1:0] r_f;
	side_t         side_f, side_r;
	logic [NB-1:0] s_r, s_d;
	dv_t           dv_d;

	assign stall = !f_rdy;

	// Radicand and branch selection.
	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_vld(valid), .in_rdy(f_rdy),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.out_vld(f_vld), .out_rdy(r_rdy),
		.r_out(r_f), .side_out(side_f)
	);

	// Square root of the radicand scaled by 2^F.
	rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_vld(f_vld), .in_rdy(r_rdy),
		.r_in(r_f), .side_in(side_f),
		.out_vld(r_vld), .out_rdy(d_rdy),
		.s_out(s_r), .side_out(side_r)
	);

	// Three numerators divided by twice the root.
	rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_vld(r_vld), .in_rdy(d_rdy),
		.s_in(s_r), .side_in(side_r),
		.out_vld(d_vld), .out_rdy(b_rdy),
		.s_out(s_d), .dv_out(dv_d)
	);

	// Saturation and output register.
	rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.in_vld(d_vld), .in_rdy(b_rdy),
		.s_in(s_d), .dv_in(dv_d),
		.out_vld(q_valid), .out_rdy(!q_stall),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw), .degenerate(degenerate)
	);

	// A degenerate result carries an all-zero quaternion.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && degenerate |-> qx == 0 && qy == 0 && qz == 0 && qw == 0)
		else $error("degenerate result with nonzero component");

	// A normal result always has a nonzero leading component.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !degenerate |-> qx != 0 || qy != 0 || qz != 0 || qw != 0)
		else $error("nondegenerate result is all zero");

	// The input can only back up when the output stage is occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !stall)
		else $error("input stalled with empty output stage");

endmodule

[sv/rmq_front.sv]
// Front stage: picks the leading component, forms the radicand and the numerators.
module rmq_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	output logic                                 in_rdy,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m00,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m01,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m02,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m10,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m11,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m12,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m20,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m21,
	input  logic signed [rmq_pkg::FIELD_W-1:0]   m22,
	output logic                                 out_vld,
	input  logic                                 out_rdy,
	output logic [((FRAC_BITS > 19) ? FRAC_BITS : 19) + 1:0] r_out,
	output rmq_pkg::side_t                       side_out
);
	import rmq_pkg::*;

	localparam int RW = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;

	logic signed [RW:0]    e00, e11, e22, one, tr, rr;
	lead_t                 lead;
	side_t                 side;
	logic [RW-1:0]         r_s1;
	side_t                 side_s1;
	logic                  v_s1;

	assign e00 = (RW+1)'(m00);
	assign e11 = (RW+1)'(m11);
	assign e22 = (RW+1)'(m22);
	assign one = (RW+1)'(1) <<< FRAC_BITS;
	assign tr  = e00 + e11 + e22;

	// Trace sign first, then the largest diagonal entry with ties to the earlier index.
	always_comb begin
		if (tr > 0) begin
			lead = LEAD_W;
		end else if (e00 < e11) begin
			lead = (e11 < e22) ? LEAD_Z : LEAD_Y;
		end else begin
			lead = (e00 < e22) ? LEAD_Z : LEAD_X;
		end
	end

	// Radicand and numerators for the chosen branch.
	always_comb begin
		side.lead = lead;
		case (lead)
			LEAD_W: begin
				rr      = tr + one;
				side.da = DIFF_W'(m21) - DIFF_W'(m12);
				side.db = DIFF_W'(m02) - DIFF_W'(m20);
				side.dc = DIFF_W'(m10) - DIFF_W'(m01);
			end
			LEAD_X: begin
				rr      = e00 - e11 - e22 + one;
				side.da = DIFF_W'(m21) - DIFF_W'(m12);
				side.db = DIFF_W'(m10) + DIFF_W'(m01);
				side.dc = DIFF_W'(m20) + DIFF_W'(m02);
			end
			LEAD_Y: begin
				rr      = e11 - e22 - e00 + one;
				side.da = DIFF_W'(m02) - DIFF_W'(m20);
				side.db = DIFF_W'(m21) + DIFF_W'(m12);
				side.dc = DIFF_W'(m01) + DIFF_W'(m10);
			end
			default: begin
				rr      = e22 - e00 - e11 + one;
				side.da = DIFF_W'(m10) - DIFF_W'(m01);
				side.db = DIFF_W'(m02) + DIFF_W'(m20);
				side.dc = DIFF_W'(m12) + DIFF_W'(m21);
			end
		endcase
	end

	assign in_rdy = !v_s1 || out_rdy;

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_rdy) begin
			v_s1 <= in_vld;
		end
	end

	// Stage payload; a negative radicand is clamped to zero.
	always_ff @(posedge clk) begin
		if (in_rdy) begin
			r_s1    <= rr[RW] ? '0 : rr[RW-1:0];
			side_s1 <= side;
		end
	end

	assign out_vld  = v_s1;
	assign r_out    = r_s1;
	assign side_out = side_s1;

endmodule

[sv/rmq_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	output logic                                 in_rdy,
	input  logic [((FRAC_BITS > 19) ? FRAC_BITS : 19) + 1:0] r_in,
	input  rmq_pkg::side_t                       side_in,
	output logic                                 out_vld,
	input  logic                                 out_rdy,
	output logic [(((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3 + FRAC_BITS) / 2 - 1:0] s_out,
	output rmq_pkg::side_t                       side_out
);
	import rmq_pkg::*;

	localparam int RW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
	localparam int NW  = RW + FRAC_BITS;
	localparam int NB  = (NW + 1) / 2;
	localparam int RMW = 2 * NB;
	localparam int TW  = RMW + 1;

	logic [RMW-1:0] rem_s  [NB];
	logic [NB-1:0]  root_s [NB];
	side_t          side_s [NB];
	logic           v_s    [NB];
	logic           rdy    [NB+1];

	assign rdy[NB] = out_rdy;
	assign in_rdy  = rdy[0];

	for (genvar k = 0; k < NB; k++) begin : g_stage
		localparam int B = NB - 1 - k;
		logic [RMW-1:0] rem_in;
		logic [NB-1:0]  root_in;
		side_t          side_pre;
		logic           v_pre;
		logic [TW-1:0]  t;
		logic           take;

		if (k == 0) begin : g_first
			assign rem_in   = RMW'(r_in) << FRAC_BITS;
			assign root_in  = '0;
			assign side_pre = side_in;
			assign v_pre    = in_vld;
		end else begin : g_next
			assign rem_in   = rem_s[k-1];
			assign root_in  = root_s[k-1];
			assign side_pre = side_s[k-1];
			assign v_pre    = v_s[k-1];
		end

		// Try setting this root bit: subtract 2*R*2^b + 2^2b if it fits.
		assign t    = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
		assign take = TW'(rem_in) >= t;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_pre;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				rem_s[k]  <= take ? RMW'(TW'(rem_in) - t) : rem_in;
				root_s[k] <= take ? (root_in | (NB'(1) << B)) : root_in;
				side_s[k] <= side_pre;
			end
		end
	end

	assign out_vld  = v_s[NB-1];
	assign s_out    = root_s[NB-1];
	assign side_out = side_s[NB-1];

endmodule

[sv/rmq_div.sv]
// Pipelined three-lane restoring divider: numerator * 2^F / (2s), rounded half away.
module rmq_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	output logic                                 in_rdy,
	input  logic [(((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3 + FRAC_BITS) / 2 - 1:0] s_in,
	input  rmq_pkg::side_t                       side_in,
	output logic                                 out_vld,
	input  logic                                 out_rdy,
	output logic [(((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3 + FRAC_BITS) / 2 - 1:0] s_out,
	output rmq_pkg::dv_t                         dv_out
);
	import rmq_pkg::*;

	localparam int RW   = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
	localparam int NB   = (RW + FRAC_BITS + 1) / 2;
	localparam int NUMW = DIFF_W + FRAC_BITS + 1;
	localparam int DW   = NB + 1 + QB;
	localparam int WW   = ((NUMW > DW) ? NUMW : DW) + 1;

	logic [NUMW-1:0] rem_s  [QB+1][3];
	logic [QB-1:0]   q_s    [QB+1][3];
	logic [2:0]      neg_s  [QB+1];
	logic [2:0]      ovf_s  [QB+1];
	logic [NB-1:0]   root_s [QB+1];
	lead_t           lead_s [QB+1];
	logic            v_s    [QB+1];
	logic            rdy    [QB+2];

	logic signed [DIFF_W-1:0] dl [3];
	logic [NB:0]              den_in;

	assign rdy[QB+1] = out_rdy;
	assign in_rdy    = rdy[0];
	assign dl[0]     = side_in.da;
	assign dl[1]     = side_in.db;
	assign dl[2]     = side_in.dc;
	assign den_in    = {s_in, 1'b0};
	assign rdy[0]    = !v_s[0] || rdy[1];

	// Setup stage: sign and magnitude, rounding bias and the overflow check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			v_s[0] <= in_vld;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic [DIFF_W-1:0] mag;
		logic [NUMW-1:0]   num;

		assign mag = dl[l][DIFF_W-1] ? DIFF_W'(-dl[l]) : DIFF_W'(dl[l]);
		assign num = (NUMW'(mag) << FRAC_BITS) + NUMW'(s_in);

		always_ff @(posedge clk) begin
			if (rdy[0]) begin
				rem_s[0][l] <= num;
				q_s[0][l]   <= '0;
				neg_s[0][l] <= dl[l][DIFF_W-1];
				ovf_s[0][l] <= WW'(num) >= (WW'(den_in) << QB);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			root_s[0] <= s_in;
			lead_s[0] <= side_in.lead;
		end
	end

	// One quotient bit per stage in every lane.
	for (genvar k = 1; k <= QB; k++) begin : g_stage
		localparam int B = QB - k;
		logic [WW-1:0] dsh;

		assign dsh    = WW'({root_s[k-1], 1'b0}) << B;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic take;

			assign take = WW'(rem_s[k-1][l]) >= dsh;

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					rem_s[k][l] <= take ? NUMW'(WW'(rem_s[k-1][l]) - dsh) : rem_s[k-1][l];
					q_s[k][l]   <= take ? (q_s[k-1][l] | (QB'(1) << B)) : q_s[k-1][l];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				root_s[k] <= root_s[k-1];
				lead_s[k] <= lead_s[k-1];
			end
		end
	end

	assign out_vld     = v_s[QB];
	assign s_out       = root_s[QB];
	assign dv_out.lead = lead_s[QB];
	assign dv_out.neg  = neg_s[QB];
	assign dv_out.ovf  = ovf_s[QB];
	assign dv_out.qa   = q_s[QB][0];
	assign dv_out.qb   = q_s[QB][1];
	assign dv_out.qc   = q_s[QB][2];

endmodule

[sv/rmq_back.sv]
// Output stage: saturation, component placement and the degenerate case.
module rmq_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	output logic                                 in_rdy,
	input  logic [(((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3 + FRAC_BITS) / 2 - 1:0] s_in,
	input  rmq_pkg::dv_t                         dv_in,
	output logic                                 out_vld,
	input  logic                                 out_rdy,
	output logic signed [rmq_pkg::FIELD_W-1:0]   qx,
	output logic signed [rmq_pkg::FIELD_W-1:0]   qy,
	output logic signed [rmq_pkg::FIELD_W-1:0]   qz,
	output logic signed [rmq_pkg::FIELD_W-1:0]   qw,
	output logic                                 degenerate
);
	import rmq_pkg::*;

	localparam int RW = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
	localparam int NB = (RW + FRAC_BITS + 1) / 2;
	localparam int LW = NB + FIELD_W;

	// Signed, saturated quotient of one lane.
	function automatic logic signed [FIELD_W-1:0] fix_lane(
		input logic [QB-1:0] q,
		input logic          neg,
		input logic          ovf
	);
		logic signed [FIELD_W-1:0] res;
		if (!neg) begin
			res = (ovf || q > QB'(131071)) ? SAT_HI : FIELD_W'(q);
		end else begin
			res = (ovf || q >= QB'(131072)) ? SAT_LO : FIELD_W'(-q);
		end
		return res;
	endfunction

	logic [NB-1:0]             half;
	logic signed [FIELD_W-1:0] lc, ca, cb, cc;
	logic signed [FIELD_W-1:0] x_c, y_c, z_c, w_c;
	logic                      dg;
	logic signed [FIELD_W-1:0] qx_s1, qy_s1, qz_s1, qw_s1;
	logic                      dg_s1, v_s1;

	// Lead component is the root halved, rounded half up.
	assign half = NB'(((NB+1)'(s_in) + (NB+1)'(1)) >> 1);
	assign lc   = (LW'(half) > LW'(131071)) ? SAT_HI : FIELD_W'(half);
	assign ca   = fix_lane(dv_in.qa, dv_in.neg[0], dv_in.ovf[0]);
	assign cb   = fix_lane(dv_in.qb, dv_in.neg[1], dv_in.ovf[1]);
	assign cc   = fix_lane(dv_in.qc, dv_in.neg[2], dv_in.ovf[2]);
	assign dg   = (s_in == '0);

	// Place the lanes according to which component led.
	always_comb begin
		case (dv_in.lead)
			LEAD_W: begin
				x_c = ca; y_c = cb; z_c = cc; w_c = lc;
			end
			LEAD_X: begin
				w_c = ca; y_c = cb; z_c = cc; x_c = lc;
			end
			LEAD_Y: begin
				w_c = ca; z_c = cb; x_c = cc; y_c = lc;
			end
			default: begin
				w_c = ca; x_c = cb; y_c = cc; z_c = lc;
			end
		endcase
	end

	assign in_rdy = !v_s1 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_rdy) begin
			v_s1 <= in_vld;
		end
	end

	// Output register; a zero root forces every component to zero.
	always_ff @(posedge clk) begin
		if (in_rdy) begin
			qx_s1 <= dg ? '0 : x_c;
			qy_s1 <= dg ? '0 : y_c;
			qz_s1 <= dg ? '0 : z_c;
			qw_s1 <= dg ? '0 : w_c;
			dg_s1 <= dg;
		end
	end

	assign out_vld    = v_s1;
	assign qx         = qx_s1;
	assign qy         = qy_s1;
	assign qz         = qz_s1;
	assign qw         = qw_s1;
	assign degenerate = dg_s1;

endmodule

[tb/rotation_matrix_to_quaternion_unit_tb.sv]
// Self-checking testbench for the rotation matrix to quaternion unit.
module rotation_matrix_to_quaternion_unit_tb;
	import rmq_pkg::*;

	localparam int FRAC      = 16;
	localparam int ONE       = 1 << FRAC;
	localparam int N_RANDOM  = 800;
	localparam int IDLE_MAX  = 3000;
	localparam int DRAIN     = 80;

	typedef logic signed [FIELD_W-1:0] fx_t;

	typedef struct packed {
		fx_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} matrix_t;

	typedef struct packed {
		fx_t  x, y, z, w;
		logic degen;
	} quat_t;

	typedef struct packed {
		matrix_t mat;
		logic    known;
		quat_t   want;
	} row_t;

	logic clk;
	logic arst_n;
	logic valid;
	logic stall;
	fx_t  m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic q_valid;
	logic q_stall;
	fx_t  qx, qy, qz, qw;
	logic degenerate;

	quat_t pending_quats[$];
	int    errors;
	int    idle_cycles;
	bit    quiet_phase;

	rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC)) i_dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.q_valid(q_valid), .q_stall(q_stall),
		.qx(qx), .qy(qy), .qz(qz), .qw(qw), .degenerate(degenerate)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Saturate to the 18-bit output range.
	function automatic longint clip18(longint v);
		if (v > 131071)
			return 131071;
		if (v < -131072)
			return -131072;
		return v;
	endfunction

	// Integer square root, floor, bit by bit.
	function automatic longint int_root(longint n);
		longint res;
		longint b;
		res = 0;
		b = longint'(1) << 62;
		while (b > n)
			b = b >>> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	// Numerator over twice the root, rounded half away from zero.
	function automatic longint ratio_round(longint d, longint root);
		longint mag;
		longint q;
		mag = (d < 0) ? -d : d;
		q = ((mag << FRAC) + root) / (root << 1);
		if (q > 262144)
			q = 262144;
		return clip18((d < 0) ? -q : q);
	endfunction

	// Expected quaternion for one matrix, by the trace-sign branch.
	function automatic quat_t quat_of_matrix(matrix_t a);
		longint m[3][3];
		longint q[4];
		longint trace, rad, root;
		lead_t  lead;
		int     li, j, k;
		quat_t  res;
		m[0][0] = a.m00; m[0][1] = a.m01; m[0][2] = a.m02;
		m[1][0] = a.m10; m[1][1] = a.m11; m[1][2] = a.m12;
		m[2][0] = a.m20; m[2][1] = a.m21; m[2][2] = a.m22;
		trace = m[0][0] + m[1][1] + m[2][2];
		j = 0;
		k = 0;
		if (trace > 0) begin
			lead = LEAD_W;
			rad = trace + ONE;
		end else begin
			if (m[0][0] < m[1][1])
				lead = (m[1][1] < m[2][2]) ? LEAD_Z : LEAD_Y;
			else
				lead = (m[0][0] < m[2][2]) ? LEAD_Z : LEAD_X;
			li = int'(lead);
			j = (li + 1) % 3;
			k = (li + 2) % 3;
			rad = m[li][li] - m[j][j] - m[k][k] + ONE;
		end
		if (rad < 0)
			rad = 0;
		root = int_root(rad << FRAC);
		res = '0;
		if (root == 0) begin
			res.degen = 1'b1;
			return res;
		end
		if (lead == LEAD_W) begin
			q[3] = clip18((root + 1) >>> 1);
			q[0] = ratio_round(m[2][1] - m[1][2], root);
			q[1] = ratio_round(m[0][2] - m[2][0], root);
			q[2] = ratio_round(m[1][0] - m[0][1], root);
		end else begin
			li = int'(lead);
			q[li] = clip18((root + 1) >>> 1);
			q[3] = ratio_round(m[k][j] - m[j][k], root);
			q[j] = ratio_round(m[j][li] + m[li][j], root);
			q[k] = ratio_round(m[k][li] + m[li][k], root);
		end
		res.x = fx_t'(q[0]);
		res.y = fx_t'(q[1]);
		res.z = fx_t'(q[2]);
		res.w = fx_t'(q[3]);
		return res;
	endfunction

	function automatic matrix_t mk(int a, int b, int c, int d, int e, int f,
			int g, int h, int i);
		matrix_t r;
		r.m00 = fx_t'(a); r.m01 = fx_t'(b); r.m02 = fx_t'(c);
		r.m10 = fx_t'(d); r.m11 = fx_t'(e); r.m12 = fx_t'(f);
		r.m20 = fx_t'(g); r.m21 = fx_t'(h); r.m22 = fx_t'(i);
		return r;
	endfunction

	function automatic quat_t qk(int x, int y, int z, int w);
		quat_t r;
		r.x = fx_t'(x); r.y = fx_t'(y); r.z = fx_t'(z); r.w = fx_t'(w);
		r.degen = 1'b0;
		return r;
	endfunction

	function automatic int rnd_range(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Random matrix: full-range noise, or diagonals shaped to pick each branch.
	function automatic matrix_t random_matrix();
		int kind, lead, d[3], i;
		matrix_t r;
		kind = $urandom_range(0, 3);
		r = mk(rnd_range(-65536, 65536), rnd_range(-65536, 65536),
			rnd_range(-65536, 65536), rnd_range(-65536, 65536), 0,
			rnd_range(-65536, 65536), rnd_range(-65536, 65536),
			rnd_range(-65536, 65536), 0);
		if (kind == 0) begin
			r = mk($urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
			return r;
		end
		if (kind == 1) begin
			for (i = 0; i < 3; i++)
				d[i] = rnd_range(-20000, 65536);
		end else begin
			lead = $urandom_range(0, 2);
			for (i = 0; i < 3; i++)
				d[i] = rnd_range(-65536, -10000);
			d[lead] = rnd_range(-8000, 65536);
		end
		r.m00 = fx_t'(d[0]);
		r.m11 = fx_t'(d[1]);
		r.m22 = fx_t'(d[2]);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Present one matrix and wait for the transaction to be taken.
	task automatic send_matrix(matrix_t a, logic known, quat_t want);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} <= a;
		valid <= 1'b1;
		do @(posedge clk); while (stall);
		pending_quats.push_back(known ? want : quat_of_matrix(a));
	endtask

	// Directed matrices, then random ones, then drain.
	initial begin
		row_t rows[$];
		row_t row;
		int   n;
		arst_n = 1'b0;
		valid = 1'b0;
		q_stall = 1'b0;
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
		errors = 0;
		quiet_phase = 1'b0;

		rows.push_back('{mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b1, qk(0, 0, 0, ONE)});
		rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, qk(32768, 0, 0, 0)});
		rows.push_back('{mk(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1'b1,
			qk(ONE, 0, 0, 0)});
		rows.push_back('{mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE), 1'b0, '0});
		rows.push_back('{mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE), 1'b0, '0});
		rows.push_back('{mk(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE), 1'b0, '0});
		rows.push_back('{mk(131071, 131071, 131071, 131071, 131071, 131071,
			131071, 131071, 131071), 1'b0, '0});
		rows.push_back('{mk(-131072, -131072, -131072, -131072, -131072,
			-131072, -131072, -131072, -131072), 1'b0, '0});
		rows.push_back('{mk(131071, -131072, 131071, -131072, 131071, -131072,
			131071, -131072, 131071), 1'b0, '0});
		rows.push_back('{mk(-131072, 131071, -131072, 131071, -131072, 131071,
			-131072, 131071, -131072), 1'b0, '0});
		// Ties between diagonal entries, and a trace of exactly zero.
		rows.push_back('{mk(0, 5, 7, 9, 0, 11, 13, 17, -ONE), 1'b0, '0});
		rows.push_back('{mk(-ONE, 5, 7, 9, 0, 11, 13, 17, 0), 1'b0, '0});
		rows.push_back('{mk(-ONE, 3, -3, 3, -ONE, 3, -3, 3, -ONE), 1'b0, '0});
		rows.push_back('{mk(ONE, 100, -100, 200, -ONE, -200, 300, -300, 0), 1'b0, '0});
		rows.push_back('{mk(-131072, 131071, 131071, -131072, -131072, 131071,
			-131072, 131071, 131071), 1'b0, '0});
		rows.push_back('{mk(32'h2AAAA, 32'h15555, 32'h2AAAA, 32'h15555, 32'h2AAAA,
			32'h15555, 32'h2AAAA, 32'h15555, 32'h2AAAA), 1'b0, '0});
		rows.push_back('{mk(32'h15555, 32'h2AAAA, 32'h15555, 32'h2AAAA, 32'h15555,
			32'h2AAAA, 32'h15555, 32'h2AAAA, 32'h15555), 1'b0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			send_matrix(row.mat, row.known, row.want);
		end

		for (n = 0; n < N_RANDOM; n++) begin
			// Alternate stretches of back-to-back traffic with idling ones.
			if (n % 100 == 0)
				quiet_phase = ($urandom_range(0, 2) == 0);
			// Hold off once until the pipeline has fully drained.
			if (n == 400) begin
				valid <= 1'b0;
				while (pending_quats.size() != 0)
					@(posedge clk);
			end
			send_matrix(random_matrix(), 1'b0, '0);
		end
		valid <= 1'b0;

		while (pending_quats.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Result side back-pressure.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = quiet_phase ? 0 : $urandom_range(0, 15);
			if (n > 0) begin
				q_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			q_stall <= 1'b0;
			do @(posedge clk); while (!q_valid);
		end
	end

	// Compare each accepted result with the oldest expected quaternion.
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && q_valid && !q_stall) begin
			if (pending_quats.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = pending_quats.pop_front();
				if (qx !== want.x)
					report_mismatch("qx", qx, want.x);
				if (qy !== want.y)
					report_mismatch("qy", qy, want.y);
				if (qz !== want.z)
					report_mismatch("qz", qz, want.z);
				if (qw !== want.w)
					report_mismatch("qw", qw, want.w);
				if (degenerate !== want.degen)
					report_mismatch("degenerate", degenerate, want.degen);
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (valid && !stall) || (q_valid && !q_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule

[sim.f]
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rmq_back.sv
sv/rotation_matrix_to_quaternion_unit.sv
tb/rotation_matrix_to_quaternion_unit_tb.sv
